/* src/tdq_pkg.sv */
// Package for the timed wait delta queue.
// Holds sizes, op and result codes and the sequencer state type; no dependencies.
`default_nettype none
package tdq_pkg;
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DELAY_BITS_DEF = 16;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned PID_W   = 8;
  localparam int unsigned DLY_W   = 16;
  localparam int unsigned SEM_W   = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned WAIT_W  = 5;

  localparam logic [OP_W-1:0] OP_ENQ    = 2'd0;
  localparam logic [OP_W-1:0] OP_SIGNAL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WAKE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOTHING = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_UP_RD,
    ST_UP_WR,
    ST_PUT,
    ST_DQ_HEAD,
    ST_DN_RD,
    ST_DN_WR,
    ST_TK_CHK,
    ST_TK_NEXT,
    ST_TK_PEEK,
    ST_TK_RE,
    ST_EMIT
  } state_e;
endpackage
`default_nettype wire

/* src/tdq_in_if.sv */
// Input channel of the timed wait delta queue: valid/ready plus one request.
// Uses tdq_pkg for field widths.
`default_nettype none
interface tdq_in_if;
  logic                       valid;
  logic                       ready;
  logic [tdq_pkg::OP_W-1:0]   op;
  logic [tdq_pkg::PID_W-1:0]  pid;
  logic [tdq_pkg::DLY_W-1:0]  delay;
  logic [tdq_pkg::SEM_W-1:0]  owner_id;
  modport source (output valid, op, pid, delay, owner_id, input ready);
  modport sink   (input valid, op, pid, delay, owner_id, output ready);
endinterface
`default_nettype wire

/* src/tdq_out_if.sv */
// Result channel of the timed wait delta queue: valid/ready plus one result.
// Uses tdq_pkg for field widths.
`default_nettype none
interface tdq_out_if;
  logic                        valid;
  logic                        ready;
  logic [tdq_pkg::KIND_W-1:0]  kind;
  logic [tdq_pkg::PID_W-1:0]   proc_id;
  logic [tdq_pkg::SEM_W-1:0]   credit_sem;
  logic [tdq_pkg::WAIT_W-1:0]  waiting;
  logic                        last;
  modport source (output valid, kind, proc_id, credit_sem, waiting, last, input ready);
  modport sink   (input valid, kind, proc_id, credit_sem, waiting, last, output ready);
endinterface
`default_nettype wire

/* src/tdq_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module tdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* src/tdq_seq.sv */
// Sequencer of the timed wait delta queue: walks, shifts and patches entries
// held in the entry RAM. Depends on tdq_pkg and the channel interfaces.
`default_nettype none
module tdq_seq #(
  parameter int unsigned DEPTH      = tdq_pkg::DEPTH_DEF,
  parameter int unsigned DELAY_BITS = tdq_pkg::DELAY_BITS_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned EW = 1 + DELAY_BITS + tdq_pkg::PID_W
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tdq_in_if.sink             in_i,
  tdq_out_if.source          out_o,
  output logic               we_o,
  output logic [AW-1:0]      waddr_o,
  output logic [EW-1:0]      wdata_o,
  output logic [AW-1:0]      raddr_o,
  input  wire logic [EW-1:0] rdata_i
);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DB = DELAY_BITS;
  localparam int unsigned PW = tdq_pkg::PID_W;

  tdq_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic [CW-1:0] tot_q, tot_d, unt_q, unt_d, pos_q, pos_d, j_q, j_d;
  logic [DB-1:0] rem_q, rem_d;
  logic [PW-1:0] pid_q, pid_d;
  logic [tdq_pkg::SEM_W-1:0] own_q, own_d;
  logic timed_q, timed_d, adj_q, adj_d, first_q, first_d;
  logic [tdq_pkg::KIND_W-1:0] rk_q, rk_d;
  logic [PW-1:0] rp_q, rp_d;
  logic [tdq_pkg::SEM_W-1:0] rs_q, rs_d;
  logic rl_q, rl_d;

  logic ov_q, ov_d;
  logic [tdq_pkg::KIND_W-1:0] ok_q, ok_d;
  logic [PW-1:0] op_q, op_d;
  logic [tdq_pkg::SEM_W-1:0] os_q, os_d;
  logic [tdq_pkg::WAIT_W-1:0] ow_q, ow_d;
  logic ol_q, ol_d;

  logic [DB-1:0] r_delta, dec_delta;
  logic [PW-1:0] r_pid;
  logic          r_timed;
  logic [31:0]   dly32;
  logic [CW+tdq_pkg::WAIT_W-1:0] tot_ext;

  assign r_pid   = rdata_i[PW-1:0];
  assign r_delta = rdata_i[PW+DB-1:PW];
  assign r_timed = rdata_i[EW-1];
  assign dly32   = {16'd0, in_i.delay};
  assign tot_ext = {{tdq_pkg::WAIT_W{1'b0}}, tot_q};
  assign dec_delta = (first_q && r_delta != '0) ? r_delta - DB'(1) : r_delta;

  assign in_i.ready       = (state_q == tdq_pkg::ST_IDLE);
  assign out_o.valid      = ov_q;
  assign out_o.kind       = ok_q;
  assign out_o.proc_id    = op_q;
  assign out_o.credit_sem = os_q;
  assign out_o.waiting    = ow_q;
  assign out_o.last       = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdq_pkg::ST_IDLE;
      ret_q   <= tdq_pkg::ST_IDLE;
      tot_q   <= '0;
      unt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      tot_q   <= tot_d;
      unt_q   <= unt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; j_q <= j_d; rem_q <= rem_d; pid_q <= pid_d; own_q <= own_d;
    timed_q <= timed_d; adj_q <= adj_d; first_q <= first_d;
    rk_q <= rk_d; rp_q <= rp_d; rs_q <= rs_d; rl_q <= rl_d;
    ok_q <= ok_d; op_q <= op_d; os_q <= os_d; ow_q <= ow_d; ol_q <= ol_d;
  end

  always_comb begin
    state_d = state_q; ret_d = ret_q; tot_d = tot_q; unt_d = unt_q;
    pos_d = pos_q; j_d = j_q; rem_d = rem_q; pid_d = pid_q; own_d = own_q;
    timed_d = timed_q; adj_d = adj_q; first_d = first_q;
    rk_d = rk_q; rp_d = rp_q; rs_d = rs_q; rl_d = rl_q;
    ok_d = ok_q; op_d = op_q; os_d = os_q; ow_d = ow_q; ol_d = ol_q;
    ov_d = ov_q && !out_o.ready;
    we_o = 1'b0; waddr_o = '0; wdata_o = rdata_i; raddr_o = '0;

    unique case (state_q)
      tdq_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          pid_d = in_i.pid;
          own_d = in_i.owner_id;
          rem_d = dly32[DB-1:0];
          rk_d  = tdq_pkg::KIND_NOTHING; rp_d = '0; rs_d = '0; rl_d = 1'b1;
          ret_d = tdq_pkg::ST_IDLE;
          state_d = tdq_pkg::ST_EMIT;
          unique case (in_i.op)
            tdq_pkg::OP_ENQ: begin
              pos_d = unt_q;
              if (tot_q >= CW'(DEPTH)) begin
                rk_d = tdq_pkg::KIND_FULL;
              end else if (dly32[DB-1:0] == '0) begin
                timed_d = 1'b0; j_d = tot_q; state_d = tdq_pkg::ST_UP_RD;
              end else begin
                timed_d = 1'b1; state_d = tdq_pkg::ST_WALK_RD;
              end
            end
            tdq_pkg::OP_SIGNAL: begin
              if (tot_q != '0) begin
                raddr_o = '0; state_d = tdq_pkg::ST_DQ_HEAD;
              end
            end
            tdq_pkg::OP_TICK: begin
              if (tot_q > unt_q) begin
                raddr_o = unt_q[AW-1:0]; first_d = 1'b1; state_d = tdq_pkg::ST_TK_CHK;
              end
            end
            default: ;
          endcase
        end
      end
      tdq_pkg::ST_WALK_RD: begin
        if (pos_q < tot_q) begin
          raddr_o = pos_q[AW-1:0]; state_d = tdq_pkg::ST_WALK_CMP;
        end else begin
          j_d = tot_q; state_d = tdq_pkg::ST_UP_RD;
        end
      end
      tdq_pkg::ST_WALK_CMP: begin
        if (r_delta <= rem_q) begin
          rem_d = rem_q - r_delta; pos_d = pos_q + CW'(1); state_d = tdq_pkg::ST_WALK_RD;
        end else begin
          we_o = 1'b1; waddr_o = pos_q[AW-1:0];
          wdata_o = {r_timed, r_delta - rem_q, r_pid};
          j_d = tot_q; state_d = tdq_pkg::ST_UP_RD;
        end
      end
      tdq_pkg::ST_UP_RD: begin
        if (j_q > pos_q) begin
          raddr_o = AW'(j_q - CW'(1)); state_d = tdq_pkg::ST_UP_WR;
        end else begin
          state_d = tdq_pkg::ST_PUT;
        end
      end
      tdq_pkg::ST_UP_WR: begin
        we_o = 1'b1; waddr_o = j_q[AW-1:0];
        j_d = j_q - CW'(1); state_d = tdq_pkg::ST_UP_RD;
      end
      tdq_pkg::ST_PUT: begin
        we_o = 1'b1; waddr_o = pos_q[AW-1:0];
        wdata_o = {timed_q, rem_q, pid_q};
        tot_d = tot_q + CW'(1);
        if (!timed_q) unt_d = unt_q + CW'(1);
        rk_d = tdq_pkg::KIND_ACCEPT; state_d = tdq_pkg::ST_EMIT;
      end
      tdq_pkg::ST_DQ_HEAD: begin
        rp_d = r_pid; rem_d = r_delta; adj_d = (unt_q == '0);
        rk_d = tdq_pkg::KIND_WAKE; pos_d = '0;
        j_d = CW'(1); state_d = tdq_pkg::ST_DN_RD;
      end
      tdq_pkg::ST_DN_RD: begin
        if (j_q < tot_q) begin
          raddr_o = j_q[AW-1:0]; state_d = tdq_pkg::ST_DN_WR;
        end else begin
          tot_d = tot_q - CW'(1);
          if (rk_q == tdq_pkg::KIND_WAKE) begin
            if (unt_q != '0) unt_d = unt_q - CW'(1);
            state_d = tdq_pkg::ST_EMIT;
          end else begin
            state_d = tdq_pkg::ST_TK_NEXT;
          end
        end
      end
      tdq_pkg::ST_DN_WR: begin
        we_o = 1'b1; waddr_o = AW'(j_q - CW'(1));
        // timed head leaves: its delta folds into the next entry
        if (adj_q && j_q == CW'(1)) wdata_o = {r_timed, r_delta + rem_q, r_pid};
        j_d = j_q + CW'(1); state_d = tdq_pkg::ST_DN_RD;
      end
      tdq_pkg::ST_TK_CHK: begin
        if (dec_delta == '0) begin
          rk_d = tdq_pkg::KIND_TIMEOUT; rp_d = r_pid; rs_d = own_q; adj_d = 1'b0;
          j_d = unt_q + CW'(1); state_d = tdq_pkg::ST_DN_RD;
        end else begin
          we_o = 1'b1; waddr_o = unt_q[AW-1:0];
          wdata_o = {r_timed, dec_delta, r_pid};
          rl_d = 1'b1; state_d = tdq_pkg::ST_EMIT;
        end
      end
      tdq_pkg::ST_TK_NEXT: begin
        if (tot_q > unt_q) begin
          raddr_o = unt_q[AW-1:0]; state_d = tdq_pkg::ST_TK_PEEK;
        end else begin
          rl_d = 1'b1; ret_d = tdq_pkg::ST_IDLE; state_d = tdq_pkg::ST_EMIT;
        end
      end
      tdq_pkg::ST_TK_PEEK: begin
        if (r_delta == '0) begin
          rl_d = 1'b0; ret_d = tdq_pkg::ST_TK_RE;
        end else begin
          rl_d = 1'b1; ret_d = tdq_pkg::ST_IDLE;
        end
        state_d = tdq_pkg::ST_EMIT;
      end
      tdq_pkg::ST_TK_RE: begin
        raddr_o = unt_q[AW-1:0]; first_d = 1'b0; state_d = tdq_pkg::ST_TK_CHK;
      end
      tdq_pkg::ST_EMIT: begin
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1; ok_d = rk_q; op_d = rp_q; os_d = rs_q; ol_d = rl_q;
          ow_d = tot_ext[tdq_pkg::WAIT_W-1:0];
          state_d = ret_q;
        end
      end
      default: state_d = tdq_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* src/timed_wait_delta_queue.sv */
// Top level of the timed wait delta queue: sequencer plus entry RAM.
// Depends on tdq_pkg, tdq_in_if, tdq_out_if, tdq_ram and tdq_seq.
//
//   channel  dir  transfer when   payload
//   in_i     in   valid & ready   op, pid, delay, owner_id
//   out_o    out  valid & ready   kind, proc_id, credit_sem, waiting, last
//
// One request at a time; the entry RAM port sets the cost. Enqueue walks the
// timed entries and shifts the later entries up; signal shifts entries down;
// each timeout release shifts the entries behind it down. Reset clears only
// the counts, no RAM pass.
// A stalled out_o holds the sequencer at its next result.
`default_nettype none
module timed_wait_delta_queue #(
  parameter int unsigned DEPTH      = tdq_pkg::DEPTH_DEF,
  parameter int unsigned DELAY_BITS = tdq_pkg::DELAY_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tdq_in_if.sink    in_i,
  tdq_out_if.source out_o
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned EW = 1 + DELAY_BITS + tdq_pkg::PID_W;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  tdq_seq #(.DEPTH(DEPTH), .DELAY_BITS(DELAY_BITS)) u_seq (
    .clk_i, .rst_ni, .in_i, .out_o,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );

  tdq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );
endmodule
`default_nettype wire

/* sim/timed_wait_delta_queue_test.sv */
// Self-checking test of timed_wait_delta_queue: directed rows, then random enqueue,
// signal and tick traffic, each transfer checked against a behavioral queue model.
// Depends on tdq_pkg, tdq_in_if, tdq_out_if and the RTL.
`timescale 1ns / 100ps
module timed_wait_delta_queue_test;

  localparam int unsigned QDEPTH = tdq_pkg::DEPTH_DEF;

  typedef struct packed {
    logic [tdq_pkg::KIND_W-1:0] kind;
    logic [tdq_pkg::PID_W-1:0]  proc_id;
    logic [tdq_pkg::SEM_W-1:0]  credit_sem;
    logic [tdq_pkg::WAIT_W-1:0] waiting;
    logic                       last;
  } wake_t;

  typedef struct {
    logic [tdq_pkg::OP_W-1:0]  op;
    logic [tdq_pkg::PID_W-1:0] pid;
    logic [tdq_pkg::DLY_W-1:0] delay;
    logic [tdq_pkg::SEM_W-1:0] owner_id;
    bit                        typed;   // row carries its own expected first result
    wake_t                     want;
  } req_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tdq_in_if  in_i ();
  tdq_out_if out_o ();

  timed_wait_delta_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // queue model: untimed FIFO in front, delta list behind
  logic [tdq_pkg::PID_W-1:0] wq_pid[$];
  logic [tdq_pkg::DLY_W-1:0] wq_delta[$];
  int unsigned      wq_untimed;
  wake_t            wake_due[$];
  wake_t            forced_due[$];   // typed-in first results of directed rows
  bit               forced_on[$];
  int unsigned      fail_cnt;

  function automatic wake_t mk(logic [tdq_pkg::KIND_W-1:0] k, logic [tdq_pkg::PID_W-1:0] p,
                               logic [tdq_pkg::SEM_W-1:0] s);
    wake_t w;
    w.kind = k;
    w.proc_id = p;
    w.credit_sem = s;
    w.waiting = tdq_pkg::WAIT_W'(wq_pid.size());
    w.last = 1'b0;
    return w;
  endfunction

  task automatic predict_queue(input req_row_t r);
    wake_t res[$];
    int unsigned pos;
    logic [tdq_pkg::DLY_W-1:0] rem;
    logic [tdq_pkg::PID_W-1:0] p;
    if (r.op == tdq_pkg::OP_ENQ) begin
      if (wq_pid.size() >= QDEPTH) begin
        res.push_back(mk(tdq_pkg::KIND_FULL, '0, '0));
      end else if (r.delay == '0) begin
        wq_pid.insert(wq_untimed, r.pid);
        wq_delta.insert(wq_untimed, '0);
        wq_untimed++;
        res.push_back(mk(tdq_pkg::KIND_ACCEPT, '0, '0));
      end else begin
        pos = wq_untimed;
        rem = r.delay;
        while (pos < wq_pid.size() && wq_delta[pos] <= rem) begin
          rem -= wq_delta[pos];
          pos++;
        end
        if (pos < wq_pid.size()) wq_delta[pos] -= rem;
        wq_pid.insert(pos, r.pid);
        wq_delta.insert(pos, rem);
        res.push_back(mk(tdq_pkg::KIND_ACCEPT, '0, '0));
      end
    end else if (r.op == tdq_pkg::OP_SIGNAL) begin
      if (wq_pid.size() == 0) begin
        res.push_back(mk(tdq_pkg::KIND_NOTHING, '0, '0));
      end else begin
        p = wq_pid[0];
        if (wq_untimed > 0) wq_untimed--;
        else if (wq_pid.size() > 1) wq_delta[1] += wq_delta[0];
        void'(wq_pid.pop_front());
        void'(wq_delta.pop_front());
        res.push_back(mk(tdq_pkg::KIND_WAKE, p, '0));
      end
    end else if (r.op == tdq_pkg::OP_TICK) begin
      if (wq_pid.size() > wq_untimed) begin
        if (wq_delta[wq_untimed] != '0) wq_delta[wq_untimed]--;
        while (wq_pid.size() > wq_untimed && wq_delta[wq_untimed] == '0) begin
          p = wq_pid[wq_untimed];
          wq_pid.delete(wq_untimed);
          wq_delta.delete(wq_untimed);
          res.push_back(mk(tdq_pkg::KIND_TIMEOUT, p, r.owner_id));
        end
      end
      if (res.size() == 0) res.push_back(mk(tdq_pkg::KIND_NOTHING, '0, '0));
    end else begin
      res.push_back(mk(tdq_pkg::KIND_NOTHING, '0, '0));
    end
    res[res.size()-1].last = 1'b1;
    foreach (res[i]) begin
      wake_due.push_back(res[i]);
      forced_on.push_back(i == 0 && r.typed);
      forced_due.push_back(r.want);
    end
  endtask

  function automatic int unsigned gap_len();
    int unsigned g;
    g = $urandom_range(0, 99);
    if (g < 45) return 0;
    if (g < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // entered and left at a falling edge; valid stays up across a zero gap
  task automatic send_req(input req_row_t r);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_i.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_i.valid <= 1'b1;
    in_i.op <= r.op;
    in_i.pid <= r.pid;
    in_i.delay <= r.delay;
    in_i.owner_id <= r.owner_id;
    @(posedge clk_i);
    while (!in_i.ready) @(posedge clk_i);
    predict_queue(r);
    @(negedge clk_i);
  endtask

  function automatic req_row_t row(logic [tdq_pkg::OP_W-1:0] op,
                                   logic [tdq_pkg::PID_W-1:0] pid,
                                   logic [tdq_pkg::DLY_W-1:0] dly,
                                   logic [tdq_pkg::SEM_W-1:0] sem);
    req_row_t r;
    r.op = op;
    r.pid = pid;
    r.delay = dly;
    r.owner_id = sem;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic req_row_t row_x(logic [tdq_pkg::OP_W-1:0] op,
                                     logic [tdq_pkg::PID_W-1:0] pid,
                                     logic [tdq_pkg::DLY_W-1:0] dly,
                                     logic [tdq_pkg::SEM_W-1:0] sem,
                                     logic [tdq_pkg::KIND_W-1:0] k,
                                     logic [tdq_pkg::PID_W-1:0] p,
                                     logic [tdq_pkg::SEM_W-1:0] s,
                                     logic [tdq_pkg::WAIT_W-1:0] w,
                                     logic l);
    req_row_t r;
    r = row(op, pid, dly, sem);
    r.typed = 1'b1;
    r.want = '{kind: k, proc_id: p, credit_sem: s, waiting: w, last: l};
    return r;
  endfunction

  // result side: random stalls, mostly short with a few long ones
  initial begin
    wake_t exp_w, got;
    bit use_typed;
    wake_t typed_w;
    int unsigned stall_n, g;
    out_o.ready = 1'b0;
    stall_n = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_n != 0) begin
        stall_n--;
        out_o.ready <= 1'b0;
      end else begin
        g = $urandom_range(0, 99);
        if (g < 3) begin
          stall_n = $urandom_range(8, 40);
          out_o.ready <= 1'b0;
        end else begin
          out_o.ready <= (g < 75);
        end
      end
      @(posedge clk_i);
      if (out_o.valid && out_o.ready) begin
        got = '{kind: out_o.kind, proc_id: out_o.proc_id, credit_sem: out_o.credit_sem,
                waiting: out_o.waiting, last: out_o.last};
        if (wake_due.size() == 0) begin
          $error("unexpected result transfer kind=%0d proc_id=%0d", got.kind, got.proc_id);
          fail_cnt++;
        end else begin
          exp_w = wake_due.pop_front();
          use_typed = forced_on.pop_front();
          typed_w = forced_due.pop_front();
          if (use_typed) exp_w = typed_w;
          if (got.kind !== exp_w.kind) begin
            $error("kind: expected %0d, got %0d", exp_w.kind, got.kind);
            fail_cnt++;
          end
          if (got.proc_id !== exp_w.proc_id) begin
            $error("proc_id: expected %0d, got %0d", exp_w.proc_id, got.proc_id);
            fail_cnt++;
          end
          if (got.credit_sem !== exp_w.credit_sem) begin
            $error("credit_sem: expected %0d, got %0d", exp_w.credit_sem, got.credit_sem);
            fail_cnt++;
          end
          if (got.waiting !== exp_w.waiting) begin
            $error("waiting: expected %0d, got %0d", exp_w.waiting, got.waiting);
            fail_cnt++;
          end
          if (got.last !== exp_w.last) begin
            $error("last: expected %0d, got %0d", exp_w.last, got.last);
            fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    req_row_t dir_rows[$];
    req_row_t r;
    int unsigned n, k, waited;
    logic [tdq_pkg::DLY_W-1:0] d;
    in_i.valid = 1'b0;
    in_i.op = tdq_pkg::OP_ENQ;
    in_i.pid = '0;
    in_i.delay = '0;
    in_i.owner_id = '0;
    wq_untimed = 0;
    fail_cnt = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir_rows.push_back(row_x(tdq_pkg::OP_SIGNAL, 8'h00, '0, '0, tdq_pkg::KIND_NOTHING,
                             '0, '0, 5'd0, 1'b1));
    dir_rows.push_back(row_x(tdq_pkg::OP_TICK, 8'h00, '0, 8'hFF, tdq_pkg::KIND_NOTHING,
                             '0, '0, 5'd0, 1'b1));
    dir_rows.push_back(row_x(tdq_pkg::OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF,
                             tdq_pkg::KIND_NOTHING, '0, '0, 5'd0, 1'b1));
    dir_rows.push_back(row_x(tdq_pkg::OP_ENQ, 8'h00, 16'd0, 8'h00, tdq_pkg::KIND_ACCEPT,
                             '0, '0, 5'd1, 1'b1));
    dir_rows.push_back(row(tdq_pkg::OP_ENQ, 8'hFF, 16'hFFFF, 8'h00));
    dir_rows.push_back(row(tdq_pkg::OP_ENQ, 8'h11, 16'd3, 8'h00));
    dir_rows.push_back(row(tdq_pkg::OP_ENQ, 8'h22, 16'd3, 8'h00));
    dir_rows.push_back(row(tdq_pkg::OP_ENQ, 8'h33, 16'd1, 8'h00));
    dir_rows.push_back(row(tdq_pkg::OP_ENQ, 8'h44, 16'd0, 8'h00));
    dir_rows.push_back(row(tdq_pkg::OP_TICK, 8'h00, '0, 8'hA5));  // releases the delay-1 waiter
    dir_rows.push_back(row(tdq_pkg::OP_TICK, 8'h00, '0, 8'h5A));
    dir_rows.push_back(row(tdq_pkg::OP_TICK, 8'h00, '0, 8'hFF));  // two release together
    dir_rows.push_back(row(tdq_pkg::OP_SIGNAL, 8'h00, '0, '0));
    dir_rows.push_back(row(tdq_pkg::OP_SIGNAL, 8'h00, '0, '0));
    dir_rows.push_back(row(tdq_pkg::OP_ENQ, 8'h55, 16'd5, 8'h00));
    dir_rows.push_back(row(tdq_pkg::OP_SIGNAL, 8'h00, '0, '0));   // timed head, delta carried on
    dir_rows.push_back(row(tdq_pkg::OP_SIGNAL, 8'h00, '0, '0));
    dir_rows.push_back(row(tdq_pkg::OP_SIGNAL, 8'h00, '0, '0));
    foreach (dir_rows[i]) send_req(dir_rows[i]);

    // fill past full with mixed waiters, then drain
    for (k = 0; k < 17; k++)
      send_req(row(tdq_pkg::OP_ENQ, 8'(k),
                   (k % 3 == 0) ? 16'd0 : 16'($urandom_range(1, 9)), '0));
    for (k = 0; k < 17; k++) send_req(row(tdq_pkg::OP_SIGNAL, '0, '0, '0));

    for (n = 0; n < 370; n++) begin
      k = $urandom_range(0, 99);
      if (k < 3) r = row(tdq_pkg::OP_UNUSED, 8'($urandom), 16'($urandom), 8'($urandom));
      else if (k < 50) begin
        case ($urandom_range(0, 4))
          0: d = '0;
          1: d = 16'($urandom);
          2: d = 16'hFFFF;
          default: d = 16'($urandom_range(1, 6));
        endcase
        r = row(tdq_pkg::OP_ENQ, 8'($urandom), d, 8'($urandom));
      end else if (k < 68) begin
        r = row(tdq_pkg::OP_SIGNAL, 8'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        r = row(tdq_pkg::OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
      end
      send_req(r);
    end
    in_i.valid <= 1'b0;

    waited = 0;
    while (wake_due.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (wake_due.size() != 0) begin
      $error("%0d expected results never arrived", wake_due.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("timed_wait_delta_queue regression: pass");
    end else begin
      $display("timed_wait_delta_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timed_wait_delta_queue regression: fail");
    $finish;
  end
endmodule
